// File: hdl/dwma_pkg.sv
`default_nettype none
package dwma_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int TEMP_WINDOW  = 5;
    localparam int PRESS_WINDOW = 20;

    localparam int TEMP_ADDR_W  = (TEMP_WINDOW > 1) ? $clog2(TEMP_WINDOW) : 1;
    localparam int PRESS_ADDR_W = (PRESS_WINDOW > 1) ? $clog2(PRESS_WINDOW) : 1;
    localparam int SLOT_W       = (TEMP_ADDR_W > PRESS_ADDR_W) ? TEMP_ADDR_W : PRESS_ADDR_W;

    // running sums never exceed window * (2^24 - 1)
    localparam int TEMP_SUM_W   = SAMPLE_W + $clog2(TEMP_WINDOW + 1);
    localparam int PRESS_SUM_W  = SAMPLE_W + $clog2(PRESS_WINDOW + 1);
    localparam int SUM_W        = (TEMP_SUM_W > PRESS_SUM_W) ? TEMP_SUM_W : PRESS_SUM_W;

    // floor(x / w) == (x * ceil(2^k / w)) >> k when x * error < 2^k
    // error stays below w, so k = sum width + clog2(w) is enough
    localparam int TEMP_SHIFT   = TEMP_SUM_W + $clog2(TEMP_WINDOW);
    localparam int PRESS_SHIFT  = PRESS_SUM_W + $clog2(PRESS_WINDOW);
    localparam int RECIP_W      = SUM_W + 1;
    localparam int PROD_W       = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] TEMP_RECIP =
        RECIP_W'(((64'd1 << TEMP_SHIFT) + 64'(TEMP_WINDOW) - 64'd1) / 64'(TEMP_WINDOW));
    localparam logic [RECIP_W-1:0] PRESS_RECIP =
        RECIP_W'(((64'd1 << PRESS_SHIFT) + 64'(PRESS_WINDOW) - 64'd1) / 64'(PRESS_WINDOW));

    localparam logic [TEMP_SUM_W-1:0] TEMP_SUM_MAX =
        TEMP_SUM_W'(TEMP_WINDOW) * TEMP_SUM_W'((64'd1 << SAMPLE_W) - 64'd1);
    localparam logic [PRESS_SUM_W-1:0] PRESS_SUM_MAX =
        PRESS_SUM_W'(PRESS_WINDOW) * PRESS_SUM_W'((64'd1 << SAMPLE_W) - 64'd1);

    typedef logic [SAMPLE_W-1:0] sample_t;

endpackage
`default_nettype wire

// File: hdl/dual_window_moving_average.sv
// dual-window moving average
// input channel s_*: one raw 24-bit sample per transaction, s_mode selects the
// ring (0 temperature, five entries; 1 pressure, twenty entries).
// result channel m_*: exactly one result per input transaction, in order:
// the floor average of the ring just written, the kind echoed in
// m_is_pressure, and m_average_valid set once the last entry of both rings
// holds a nonzero sample.
// m_valid follows the input transaction through four register stages (ring
// read, sum update, reciprocal multiply, output).
// throughput: one transaction per cycle unless m_ready stalls; ring entries
// sit in two synchronous memories, each written back as its transaction
// leaves the read stage; back-to-back samples on one entry are forwarded.
// reset (aresetn low, synchronous) clears sums, slot pointers, per-entry
// valid bits and the pipeline; no clearing pass is needed, entries never
// written read as zero.
// when the receiver stalls each stage holds while the next stage is full, so
// up to four transactions are taken before s_ready drops.
`default_nettype none
module dual_window_moving_average (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_mode,
    input  wire logic [dwma_pkg::SAMPLE_W-1:0] s_raw_sample,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_average_valid,
    output logic [dwma_pkg::SAMPLE_W-1:0]     m_average_value,
    output logic                              m_is_pressure
);

    // ring memories
    dwma_pkg::sample_t temp_mem  [dwma_pkg::TEMP_WINDOW];
    dwma_pkg::sample_t press_mem [dwma_pkg::PRESS_WINDOW];

    logic [dwma_pkg::TEMP_WINDOW-1:0]  temp_vld_reg;
    logic [dwma_pkg::PRESS_WINDOW-1:0] press_vld_reg;

    logic [dwma_pkg::TEMP_ADDR_W-1:0]  temp_slot_reg, temp_slot_next;
    logic [dwma_pkg::PRESS_ADDR_W-1:0] press_slot_reg, press_slot_next;

    logic [dwma_pkg::TEMP_SUM_W-1:0]   temp_total_reg, temp_total_next;
    logic [dwma_pkg::PRESS_SUM_W-1:0]  press_total_reg, press_total_next;
    logic                              temp_last_reg, temp_last_next;
    logic                              press_last_reg, press_last_next;

    // stage 1: read data back
    logic                              v1_reg;
    logic                              mode1_reg;
    logic [dwma_pkg::SLOT_W-1:0]       addr1_reg;
    dwma_pkg::sample_t                 sample1_reg;
    dwma_pkg::sample_t                 temp_rd_reg;
    dwma_pkg::sample_t                 press_rd_reg;
    logic                              ent_vld1_reg;
    logic                              fwd1_reg;
    dwma_pkg::sample_t                 fwd_data1_reg;

    // stage 2: updated sum
    logic                              v2_reg;
    logic                              mode2_reg;
    logic                              avgv2_reg;
    logic [dwma_pkg::SUM_W-1:0]        op2_reg;

    // stage 3: product
    logic                              v3_reg;
    logic                              mode3_reg;
    logic                              avgv3_reg;
    logic [dwma_pkg::PROD_W-1:0]       prod3_reg;

    // output register
    logic                              vo_reg;
    logic                              avgv_o_reg;
    dwma_pkg::sample_t                 avg_o_reg;
    logic                              mode_o_reg;

    logic free_o, free3, free2, free1;
    logic s_fire, s1_fire;
    logic [dwma_pkg::SLOT_W-1:0] s_addr;
    dwma_pkg::sample_t old_sample;
    logic [dwma_pkg::PROD_W-1:0] temp_quot, press_quot;

    assign free_o  = !vo_reg || m_ready;
    assign free3   = !v3_reg || free_o;
    assign free2   = !v2_reg || free3;
    assign free1   = !v1_reg || free2;
    assign s_ready = free1;
    assign s_fire  = s_valid && free1;
    assign s1_fire = v1_reg && free2;

    assign s_addr = s_mode ? dwma_pkg::SLOT_W'(press_slot_reg)
                           : dwma_pkg::SLOT_W'(temp_slot_reg);

    always_comb begin
        temp_slot_next  = temp_slot_reg;
        press_slot_next = press_slot_reg;
        if (s_fire && !s_mode) begin
            if (temp_slot_reg == dwma_pkg::TEMP_ADDR_W'(dwma_pkg::TEMP_WINDOW - 1)) begin
                temp_slot_next = '0;
            end else begin
                temp_slot_next = temp_slot_reg + 1'b1;
            end
        end
        if (s_fire && s_mode) begin
            if (press_slot_reg == dwma_pkg::PRESS_ADDR_W'(dwma_pkg::PRESS_WINDOW - 1)) begin
                press_slot_next = '0;
            end else begin
                press_slot_next = press_slot_reg + 1'b1;
            end
        end
    end

    // oldest entry: forwarded write, stored value, or zero if never written
    always_comb begin
        if (fwd1_reg) begin
            old_sample = fwd_data1_reg;
        end else if (ent_vld1_reg) begin
            old_sample = mode1_reg ? press_rd_reg : temp_rd_reg;
        end else begin
            old_sample = '0;
        end
    end

    always_comb begin
        temp_total_next  = temp_total_reg;
        press_total_next = press_total_reg;
        temp_last_next   = temp_last_reg;
        press_last_next  = press_last_reg;
        if (s1_fire && !mode1_reg) begin
            temp_total_next = temp_total_reg - dwma_pkg::TEMP_SUM_W'(old_sample)
                            + dwma_pkg::TEMP_SUM_W'(sample1_reg);
            if (addr1_reg == dwma_pkg::SLOT_W'(dwma_pkg::TEMP_WINDOW - 1)) begin
                temp_last_next = (sample1_reg != '0);
            end
        end
        if (s1_fire && mode1_reg) begin
            press_total_next = press_total_reg - dwma_pkg::PRESS_SUM_W'(old_sample)
                             + dwma_pkg::PRESS_SUM_W'(sample1_reg);
            if (addr1_reg == dwma_pkg::SLOT_W'(dwma_pkg::PRESS_WINDOW - 1)) begin
                press_last_next = (sample1_reg != '0);
            end
        end
    end

    // memory read and write-back
    always_ff @(posedge aclk) begin
        if (free1) begin
            temp_rd_reg  <= temp_mem[temp_slot_reg];
            press_rd_reg <= press_mem[press_slot_reg];
        end
        if (s1_fire && !mode1_reg) begin
            temp_mem[addr1_reg[dwma_pkg::TEMP_ADDR_W-1:0]] <= sample1_reg;
        end
        if (s1_fire && mode1_reg) begin
            press_mem[addr1_reg[dwma_pkg::PRESS_ADDR_W-1:0]] <= sample1_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_vld_reg    <= '0;
            press_vld_reg   <= '0;
            temp_slot_reg   <= '0;
            press_slot_reg  <= '0;
            temp_total_reg  <= '0;
            press_total_reg <= '0;
            temp_last_reg   <= 1'b0;
            press_last_reg  <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            vo_reg          <= 1'b0;
            fwd1_reg        <= 1'b0;
        end else begin
            temp_slot_reg   <= temp_slot_next;
            press_slot_reg  <= press_slot_next;
            temp_total_reg  <= temp_total_next;
            press_total_reg <= press_total_next;
            temp_last_reg   <= temp_last_next;
            press_last_reg  <= press_last_next;
            if (s1_fire && !mode1_reg) begin
                temp_vld_reg[addr1_reg[dwma_pkg::TEMP_ADDR_W-1:0]] <= 1'b1;
            end
            if (s1_fire && mode1_reg) begin
                press_vld_reg[addr1_reg[dwma_pkg::PRESS_ADDR_W-1:0]] <= 1'b1;
            end
            if (free1) begin
                v1_reg   <= s_valid;
                // same entry written this cycle: memory still returns the old word
                fwd1_reg <= s_valid && s1_fire && (mode1_reg == s_mode)
                            && (addr1_reg == s_addr);
            end
            if (free2) begin
                v2_reg <= s1_fire;
            end
            if (free3) begin
                v3_reg <= v2_reg;
            end
            if (free_o) begin
                vo_reg <= v3_reg;
            end
        end
    end

    assign temp_quot  = prod3_reg >> dwma_pkg::TEMP_SHIFT;
    assign press_quot = prod3_reg >> dwma_pkg::PRESS_SHIFT;

    // payload
    always_ff @(posedge aclk) begin
        if (free1) begin
            mode1_reg     <= s_mode;
            addr1_reg     <= s_addr;
            sample1_reg   <= s_raw_sample;
            ent_vld1_reg  <= s_mode ? press_vld_reg[press_slot_reg]
                                    : temp_vld_reg[temp_slot_reg];
            fwd_data1_reg <= sample1_reg;
        end
        if (free2) begin
            mode2_reg <= mode1_reg;
            avgv2_reg <= temp_last_next && press_last_next;
            op2_reg   <= mode1_reg ? dwma_pkg::SUM_W'(press_total_next)
                                   : dwma_pkg::SUM_W'(temp_total_next);
        end
        if (free3) begin
            mode3_reg <= mode2_reg;
            avgv3_reg <= avgv2_reg;
            prod3_reg <= dwma_pkg::PROD_W'(op2_reg)
                       * dwma_pkg::PROD_W'(mode2_reg ? dwma_pkg::PRESS_RECIP
                                                     : dwma_pkg::TEMP_RECIP);
        end
        if (free_o) begin
            mode_o_reg <= mode3_reg;
            avgv_o_reg <= avgv3_reg;
            avg_o_reg  <= mode3_reg ? press_quot[dwma_pkg::SAMPLE_W-1:0]
                                    : temp_quot[dwma_pkg::SAMPLE_W-1:0];
        end
    end

    assign m_valid         = vo_reg;
    assign m_average_valid = avgv_o_reg;
    assign m_average_value = avg_o_reg;
    assign m_is_pressure   = mode_o_reg;

    a_temp_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        temp_slot_reg <= dwma_pkg::TEMP_ADDR_W'(dwma_pkg::TEMP_WINDOW - 1))
        else $error("temperature slot out of range");

    a_press_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        press_slot_reg <= dwma_pkg::PRESS_ADDR_W'(dwma_pkg::PRESS_WINDOW - 1))
        else $error("pressure slot out of range");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        temp_total_reg <= dwma_pkg::TEMP_SUM_MAX && press_total_reg <= dwma_pkg::PRESS_SUM_MAX)
        else $error("running sum beyond window bound");

    a_fwd_needs_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd1_reg |-> v1_reg)
        else $error("forward flag without a transaction in read stage");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg || (!v2_reg && !v3_reg && !vo_reg)) |-> s_ready)
        else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire
